// ===== hw/rtl/srgb_to_xyb_pixel_converter_top_macros.svh =====
// Assertion helpers shared by the converter modules
`ifndef SRGB_TO_XYB_PIXEL_CONVERTER_TOP_MACROS_SVH
`define SRGB_TO_XYB_PIXEL_CONVERTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SRGBX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
// next-cycle implication
`define SRGBX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define SRGBX_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SRGBX_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/srgbx_pkg.sv =====
package srgbx_pkg;

    localparam int CFG_DIM_W         = 9;
    localparam int MAX_GROUP_DIM_DEF = 256;
    localparam int SAMPLE_W          = 16;
    localparam int LIN_W             = 23;
    localparam int MIX_W             = 25;
    localparam int GAM_W             = 22;
    localparam int P_W               = 49;
    localparam int Q_DEPTH           = 4;
    localparam int NSTG              = 13;

    // curve and cube-root constants
    localparam logic [11:0]        SEG_KNEE   = 12'd2650;
    localparam logic [28:0]        SEG_SLOPE  = 29'd332427809;
    localparam logic [11:0]        POW_OFFSET = 12'd3604;
    localparam logic [31:0]        POW_SCALE  = 32'd4071059048;
    localparam logic [29:0]        POW_PIVOT  = 30'd1072632447;
    localparam logic signed [9:0]  SRGB_K     = 10'sd410;
    localparam logic signed [11:0] CBRT_K     = 12'sd1365;
    localparam logic [8:0]         MIX_BIAS   = 9'd249;
    localparam logic [13:0]        GAM_OFFSET = 14'd10220;
    localparam logic [10:0]        SRGB_EXP0  = 11'd975;
    localparam logic [10:0]        CBRT_EXP0  = 11'd1007;
    localparam logic [10:0]        UNPACK_TOP = 11'd1027;

    // opsin matrix: rows L, M, S; columns R, G, B
    localparam logic [15:0] MIX_K [3][3] = '{
        '{16'd307, 16'd637,   16'd319},
        '{16'd471, 16'd45351, 16'd319},
        '{16'd997, 16'd3355,  16'd565}
    };
    localparam int MIX_SH [3][3] = '{
        '{10, 10, 12},
        '{11, 16, 12},
        '{12, 14, 10}
    };

    typedef enum logic [1:0] {
        REG_LINEAR = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red;
        logic [SAMPLE_W-1:0] green;
        logic [SAMPLE_W-1:0] blue;
        logic                last;
    } t_q_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [5:0] f_lead49(input logic [P_W-1:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < P_W; i++) begin
            if (v[i]) n = 6'(i);
        end
        return n;
    endfunction

    function automatic logic [4:0] f_lead25(input logic [MIX_W-1:0] v);
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < MIX_W; i++) begin
            if (v[i]) n = 5'(i);
        end
        return n;
    endfunction

    // exponent/mantissa pattern back to a value scaled by 2^16
    function automatic logic [20:0] f_unpack(input logic [29:0] qd);
        logic [10:0] sh;
        logic [20:0] m;
        sh = UNPACK_TOP - {1'b0, qd[29:20]};
        m  = {1'b1, qd[19:0]};
        return (sh > 11'd20) ? 21'd0 : (m >> sh[4:0]);
    endfunction

endpackage

// ===== hw/rtl/srgbx_front.sv =====
`include "srgb_to_xyb_pixel_converter_top_macros.svh"
module srgbx_front import srgbx_pkg::*; #(
    parameter int MAX_GROUP_DIM = MAX_GROUP_DIM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [SAMPLE_W-1:0]  i_red,
    input  logic [SAMPLE_W-1:0]  i_green,
    input  logic [SAMPLE_W-1:0]  i_blue,
    input  logic [CFG_DIM_W-1:0] i_cfg_width,
    input  logic [CFG_DIM_W-1:0] i_cfg_height,
    input  t_q_stat              i_q_stat,
    output logic                 o_push,
    output t_q_item              o_item
);

    localparam int CNT_W = $clog2(MAX_GROUP_DIM);
    localparam int DIM_W = ($clog2(MAX_GROUP_DIM + 1) > CFG_DIM_W) ?
                           $clog2(MAX_GROUP_DIM + 1) : CFG_DIM_W;
    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_GROUP_DIM);

    logic [CNT_W-1:0] r_col, r_row;
    logic [DIM_W-1:0] eff_w, eff_h, cfg_w, cfg_h;
    logic             accept, col_end, row_end;

    assign o_stall = i_q_stat.full;
    assign accept  = i_valid && !i_q_stat.full;

    // clamp group size to 1..MAX_GROUP_DIM
    always_comb begin
        cfg_w = DIM_W'(i_cfg_width);
        cfg_h = DIM_W'(i_cfg_height);
        eff_w = (cfg_w == '0) ? DIM_W'(1) : ((cfg_w > DIM_MAX) ? DIM_MAX : cfg_w);
        eff_h = (cfg_h == '0) ? DIM_W'(1) : ((cfg_h > DIM_MAX) ? DIM_MAX : cfg_h);
    end

    assign col_end = (DIM_W'(r_col) + DIM_W'(1)) >= eff_w;
    assign row_end = (DIM_W'(r_row) + DIM_W'(1)) >= eff_h;

    // tag and forward the pixel
    assign o_push       = accept;
    assign o_item.red   = i_red;
    assign o_item.green = i_green;
    assign o_item.blue  = i_blue;
    assign o_item.last  = col_end && row_end;

    // advance the raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (col_end) begin
                r_col <= '0;
                r_row <= row_end ? '0 : r_row + CNT_W'(1);
            end else begin
                r_col <= r_col + CNT_W'(1);
            end
        end
    end

    `SRGBX_ASSERT_NXT(a_group_wrap, i_clk, i_rst_n, accept && col_end && row_end, (r_col == '0) && (r_row == '0))
    `SRGBX_ASSERT_NXT(a_col_step, i_clk, i_rst_n, accept && !col_end, r_col == $past(r_col) + CNT_W'(1))
    `SRGBX_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_q_stat.full, !o_push)

endmodule

// ===== hw/rtl/srgbx_fifo.sv =====
`include "srgb_to_xyb_pixel_converter_top_macros.svh"
module srgbx_fifo import srgbx_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_item i_item,
    input  logic    i_pop,
    output t_q_item o_item,
    output t_q_stat o_stat
);

    localparam int PTR_W = $clog2(Q_DEPTH);

    t_q_item          r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;

    assign o_item       = r_mem[r_rd];
    assign o_stat.full  = (r_count == (PTR_W+1)'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // store entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

    // move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PTR_W'(1);
            if (i_pop)  r_rd <= r_rd + PTR_W'(1);
            if (i_push && !i_pop)      r_count <= r_count + (PTR_W+1)'(1);
            else if (!i_push && i_pop) r_count <= r_count - (PTR_W+1)'(1);
        end
    end

    `SRGBX_ASSERT_NXT(a_cnt_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + (PTR_W+1)'(1))
    `SRGBX_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

// ===== hw/rtl/srgbx_back.sv =====
`include "srgb_to_xyb_pixel_converter_top_macros.svh"
module srgbx_back import srgbx_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_linear,
    input  t_q_stat            i_q_stat,
    input  t_q_item            i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_x_chroma,
    output logic [15:0]        o_luma_y,
    output logic signed [16:0] o_b_minus_y,
    output logic               o_last_of_group
);

    logic            en;
    logic [NSTG-1:0] r_vld, r_flag;

    logic [SAMPLE_W-1:0] samp [3];
    // curve stages
    logic [SAMPLE_W-1:0] r1_raw [3], r2_raw [3], r3_raw [3], r4_raw [3], r5_raw [3];
    logic                r1_sml [3], r2_sml [3], r3_sml [3], r4_sml [3], r5_sml [3];
    logic [8:0]          r1_lo [3], r2_lo [3], r3_lo [3], r4_lo [3], r5_lo [3];
    logic [P_W-1:0]      r1_p [3], r2_p [3];
    logic [5:0]          r2_lg [3];
    logic [17:0]         r2_sq [3], r3_sq [3], r4_sq [3], r5_sq [3];
    logic signed [32:0]  r3_diff [3];
    logic [29:0]         r4_qd [3];
    logic [20:0]         r5_post [3];
    logic [LIN_W-1:0]    r6_lin [3];
    // mixing and cube-root stages
    logic [MIX_W-1:0]    r7_term [3][3];
    logic [MIX_W-1:0]    r8_mix [3], r9_mix [3];
    logic [4:0]          r9_lg [3];
    logic signed [32:0]  r10_diff [3];
    logic [29:0]         r11_qd [3];
    logic signed [GAM_W-1:0] r12_gam [3];
    logic signed [15:0]  r_x;
    logic [15:0]         r_y;
    logic signed [16:0]  r_b;

    logic [40:0]         c1_lo [3];
    logic [33:0]         c2_sq [3];
    logic [P_W-1:0]      c3_norm [3];
    logic [30:0]         c3_pd [3];
    logic signed [42:0]  c4_prod [3];
    logic [38:0]         c6_prod [3];
    logic [38:0]         c7_prod [3][3];
    logic [MIX_W-1:0]    c10_norm [3];
    logic [30:0]         c10_pd [3];
    logic signed [44:0]  c11_prod [3];
    logic signed [22:0]  c_xd, c_yd, c_xv, c_yv;
    logic signed [23:0]  c_bv;

    assign en    = !r_vld[NSTG-1] || !i_stall;
    assign o_pop = en && !i_q_stat.empty;

    assign samp[0] = i_item.red;
    assign samp[1] = i_item.green;
    assign samp[2] = i_item.blue;

    // control: valid and group flag travel with the pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) r_flag <= {r_flag[NSTG-2:0], i_item.last};
    end

    // datapath arithmetic per stage
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            c1_lo[c]   = 41'(samp[c][11:0]) * 41'(SEG_SLOPE);
            c2_sq[c]   = 34'(r1_p[c][48:32]) * 34'(r1_p[c][48:32]);
            c3_norm[c] = r2_p[c] << (6'd48 - r2_lg[c]);
            c3_pd[c]   = {SRGB_EXP0 + 11'(r2_lg[c]), c3_norm[c][47:28]};
            c4_prod[c] = r3_diff[c] * SRGB_K;
            c6_prod[c] = 39'(r5_sq[c]) * 39'(r5_post[c]);
            for (int r = 0; r < 3; r++) begin
                c7_prod[r][c] = 39'(r6_lin[c]) * 39'(MIX_K[r][c]);
            end
            c10_norm[c] = r9_mix[c] << (5'd24 - r9_lg[c]);
            c10_pd[c]   = {CBRT_EXP0 + 11'(r9_lg[c]), c10_norm[c][23:4]};
            c11_prod[c] = r10_diff[c] * CBRT_K;
        end
    end

    // linearize each channel, or pass it through when i_linear is set
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r1_raw[c] <= samp[c];
                r1_sml[c] <= samp[c] <= SAMPLE_W'(SEG_KNEE);
                r1_lo[c]  <= c1_lo[c][40:32];
                r1_p[c]   <= (P_W'(samp[c]) + P_W'(POW_OFFSET)) * P_W'(POW_SCALE);

                r2_raw[c] <= r1_raw[c];
                r2_sml[c] <= r1_sml[c];
                r2_lo[c]  <= r1_lo[c];
                r2_p[c]   <= r1_p[c];
                r2_lg[c]  <= f_lead49(r1_p[c]);
                r2_sq[c]  <= c2_sq[c][33:16];

                r3_raw[c]  <= r2_raw[c];
                r3_sml[c]  <= r2_sml[c];
                r3_lo[c]   <= r2_lo[c];
                r3_sq[c]   <= r2_sq[c];
                r3_diff[c] <= $signed({2'b00, c3_pd[c]}) - $signed({3'b000, POW_PIVOT});

                r4_raw[c] <= r3_raw[c];
                r4_sml[c] <= r3_sml[c];
                r4_lo[c]  <= r3_lo[c];
                r4_sq[c]  <= r3_sq[c];
                r4_qd[c]  <= c4_prod[c][39:10] + POW_PIVOT;

                r5_raw[c]  <= r4_raw[c];
                r5_sml[c]  <= r4_sml[c];
                r5_lo[c]   <= r4_lo[c];
                r5_sq[c]   <= r4_sq[c];
                r5_post[c] <= f_unpack(r4_qd[c]);

                if (i_linear)       r6_lin[c] <= LIN_W'(r5_raw[c]);
                else if (r5_sml[c]) r6_lin[c] <= LIN_W'(r5_lo[c]);
                else                r6_lin[c] <= c6_prod[c][38:16];
            end
        end
    end

    // mix into L, M, S and take cube roots
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r7_term[r][c] <= MIX_W'(c7_prod[r][c] >> MIX_SH[r][c]);
                end
                r8_mix[r]   <= r7_term[r][0] + r7_term[r][1] + r7_term[r][2]
                               + MIX_W'(MIX_BIAS);
                r9_mix[r]   <= r8_mix[r];
                r9_lg[r]    <= f_lead25(r8_mix[r]);
                r10_diff[r] <= $signed({2'b00, c10_pd[r]}) - $signed({3'b000, POW_PIVOT});
                r11_qd[r]   <= c11_prod[r][41:12] + POW_PIVOT;
                r12_gam[r]  <= $signed(GAM_W'(f_unpack(r11_qd[r])))
                               - $signed(GAM_W'(GAM_OFFSET));
            end
        end
    end

    // form X, Y and B-minus-Y
    always_comb begin
        c_xd = 23'(r12_gam[0]) - 23'(r12_gam[1]);
        c_yd = 23'(r12_gam[0]) + 23'(r12_gam[1]);
        c_xv = c_xd >>> 1;
        c_yv = c_yd >>> 1;
        c_bv = 24'(r12_gam[2]) - 24'(c_yv);
    end

    // saturate into the output register
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (c_xv < -23'sd32768)     r_x <= -16'sd32768;
            else if (c_xv > 23'sd32767) r_x <= 16'sd32767;
            else                        r_x <= c_xv[15:0];

            if (c_yv < 23'sd0)          r_y <= 16'd0;
            else if (c_yv > 23'sd65535) r_y <= 16'hFFFF;
            else                        r_y <= c_yv[15:0];

            if (c_bv < -24'sd65536)     r_b <= -17'sd65536;
            else if (c_bv > 24'sd65535) r_b <= 17'sd65535;
            else                        r_b <= c_bv[16:0];
        end
    end

    assign o_valid         = r_vld[NSTG-1];
    assign o_last_of_group = r_flag[NSTG-1];
    assign o_x_chroma      = r_x;
    assign o_luma_y        = r_y;
    assign o_b_minus_y     = r_b;

    `SRGBX_ASSERT_NXT(a_stage_adv, i_clk, i_rst_n, en && r_vld[0], r_vld[1])
    `SRGBX_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, r_vld[NSTG-1] && i_stall, r_vld[NSTG-1] && (r_flag[NSTG-1] == $past(r_flag[NSTG-1])))

endmodule

// ===== hw/rtl/srgb_to_xyb_pixel_converter_top.sv =====
// Throughput: one pixel per cycle unless i_stall holds the output; a 4-entry
// queue decouples intake from the 13-stage pipeline, which advances whenever
// its output register is free.
// Reset (i_rst_n low, synchronous): raster counters and queue clear, registers
// return to linear_light_input 0 and a 256 by 256 pixel group.
module srgb_to_xyb_pixel_converter_top import srgbx_pkg::*; #(
    parameter int MAX_GROUP_DIM = MAX_GROUP_DIM_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [15:0]        i_red_sample,
    input  logic [15:0]        i_green_sample,
    input  logic [15:0]        i_blue_sample,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_x_chroma,
    output logic [15:0]        o_luma_y,
    output logic signed [16:0] o_b_minus_y,
    output logic               o_last_of_group,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic                 r_linear;
    logic [CFG_DIM_W-1:0] r_width, r_height;
    t_reg_idx             reg_idx;
    logic                 cfg_wr, push, pop;
    t_q_item              push_item, pop_item;
    t_q_stat              q_stat;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_linear <= 1'b0;
            r_width  <= CFG_DIM_W'(256);
            r_height <= CFG_DIM_W'(256);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LINEAR: r_linear <= pwdata[0];
                REG_WIDTH:  r_width  <= pwdata[CFG_DIM_W-1:0];
                REG_HEIGHT: r_height <= pwdata[CFG_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (reg_idx)
            REG_LINEAR: prdata = 32'(r_linear);
            REG_WIDTH:  prdata = 32'(r_width);
            REG_HEIGHT: prdata = 32'(r_height);
            default:    prdata = '0;
        endcase
    end

    srgbx_front #(
        .MAX_GROUP_DIM(MAX_GROUP_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_red        (i_red_sample),
        .i_green      (i_green_sample),
        .i_blue       (i_blue_sample),
        .i_cfg_width  (r_width),
        .i_cfg_height (r_height),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_item       (push_item)
    );

    srgbx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_item  (pop_item),
        .o_stat  (q_stat)
    );

    srgbx_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_linear        (r_linear),
        .i_q_stat        (q_stat),
        .i_item          (pop_item),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_x_chroma      (o_x_chroma),
        .o_luma_y        (o_luma_y),
        .o_b_minus_y     (o_b_minus_y),
        .o_last_of_group (o_last_of_group)
    );

endmodule

// ===== dv/tb.sv =====
module tb import srgbx_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic [63:0] u64_t;

    typedef struct {
        logic signed [15:0] x;
        logic [15:0]        y;
        logic signed [16:0] bmy;
        logic               last;
    } xyb_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [15:0]        i_red_sample;
    logic [15:0]        i_green_sample;
    logic [15:0]        i_blue_sample;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_x_chroma;
    logic [15:0]        o_luma_y;
    logic signed [16:0] o_b_minus_y;
    logic               o_last_of_group;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // predictor copy of registers and raster position
    logic        mdl_linear;
    logic [8:0]  mdl_width;
    logic [8:0]  mdl_height;
    int unsigned mdl_col;
    int unsigned mdl_row;

    xyb_t pending_xyb[$];
    int   mismatches;
    bit   calm;
    int   hold_req;
    int   hold_left;

    srgb_to_xyb_pixel_converter_top u_dut (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // run limit
    initial begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic u64_t lead_pos(u64_t v);
        u64_t n;
        n = 0;
        while (v > 1) begin
            v = v >> 1;
            n++;
        end
        return n;
    endfunction

    function automatic u64_t frac20(u64_t v, u64_t lg);
        u64_t f;
        f = (lg >= 20) ? (v >> (lg - 20)) : (v << (20 - lg));
        return f & 64'hFFFFF;
    endfunction

    function automatic u64_t decode_pow(u64_t d);
        u64_t e, m, sh;
        e  = (d >> 20) & 64'h3FF;
        m  = (d & 64'hFFFFF) | (64'd1 << 20);
        sh = 64'd1027 - e;
        return (sh > 63) ? 64'd0 : (m >> sh);
    endfunction

    function automatic u64_t linearise(u64_t s);
        u64_t p, lg, pd, qd, post, ps;
        if (s <= 2650)
            return (s * 64'd332427809) >> 32;
        p    = (s + 64'd3604) * 64'd4071059048;
        lg   = lead_pos(p);
        pd   = frac20(p, lg) | ((64'h3FE + lg - 64'd47) << 20);
        qd   = (((pd - 64'd1072632447) * 64'd410) >> 10) + 64'd1072632447;
        post = decode_pow(qd);
        ps   = p >> 32;
        return (((ps * ps) >> 16) * post) >> 16;
    endfunction

    function automatic u64_t cube_rt(u64_t v);
        u64_t lg, pd, qd;
        lg = lead_pos(v);
        pd = frac20(v, lg) | ((64'h3FE + lg - 64'd15) << 20);
        qd = (((pd - 64'd1072632447) * 64'd1365) >> 12) + 64'd1072632447;
        return decode_pow(qd);
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int unsigned clip_dim(logic [8:0] d);
        if (d == 0)
            return 1;
        return (d > 256) ? 256 : d;
    endfunction

    // work out the XYB result of one pixel and advance the raster position
    function automatic xyb_t convert_pixel(logic [15:0] r_in, logic [15:0] g_in,
                                           logic [15:0] b_in);
        u64_t        r, g, b, lm, mm, sm;
        longint      lg, mg, sg, xv, yv, bv;
        int unsigned w, h;
        bit          col_end, row_end;
        xyb_t        res;
        r = r_in;
        g = g_in;
        b = b_in;
        w = clip_dim(mdl_width);
        h = clip_dim(mdl_height);
        col_end = (mdl_col + 1 >= w);
        row_end = (mdl_row + 1 >= h);
        if (!mdl_linear) begin
            r = linearise(r);
            g = linearise(g);
            b = linearise(b);
        end
        lm = ((r * 307) >> 10) + ((g * 637) >> 10) + ((b * 319) >> 12) + 249;
        mm = ((r * 471) >> 11) + ((g * 45351) >> 16) + ((b * 319) >> 12) + 249;
        sm = ((r * 997) >> 12) + ((g * 3355) >> 14) + ((b * 565) >> 10) + 249;
        lg = longint'(cube_rt(lm)) - 10220;
        mg = longint'(cube_rt(mm)) - 10220;
        sg = longint'(cube_rt(sm)) - 10220;
        xv = (lg - mg) >>> 1;
        yv = (lg + mg) >>> 1;
        bv = sg - yv;
        res.x    = 16'(sat(xv, -32768, 32767));
        res.y    = 16'(sat(yv, 0, 65535));
        res.bmy  = 17'(sat(bv, -65536, 65535));
        res.last = col_end && row_end;
        if (col_end) begin
            mdl_col = 0;
            mdl_row = row_end ? 0 : mdl_row + 1;
        end else begin
            mdl_col++;
        end
        return res;
    endfunction

    // offer one pixel, hold it until the transfer happens, then record its result
    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        if (!calm && $urandom_range(99) < 24) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_red_sample   <= r;
        i_green_sample <= g;
        i_blue_sample  <= b;
        do @(posedge i_clk); while (o_stall);
        pending_xyb.push_back(convert_pixel(r, g, b));
    endtask

    // drop valid and wait for the pipeline to empty
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_xyb.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic reg_write(t_reg_idx idx, logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(4 * int'(idx));
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_LINEAR: mdl_linear = val[0];
            REG_WIDTH:  mdl_width  = val[8:0];
            default:    mdl_height = val[8:0];
        endcase
    endtask

    task automatic configure(logic lin, logic [8:0] w, logic [8:0] h);
        drain();
        reg_write(REG_LINEAR, {31'd0, lin});
        reg_write(REG_WIDTH, {23'd0, w});
        reg_write(REG_HEIGHT, {23'd0, h});
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'($urandom_range(2640, 2660));
            1:       return 16'($urandom_range(0, 3));
            2:       return 16'($urandom_range(65530, 65535));
            3:       return 16'($urandom_range(0, 300));
            default: return 16'($urandom);
        endcase
    endfunction

    // check each result transfer against the oldest expectation; drive receiver stall
    always @(posedge i_clk) begin
        xyb_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_xyb.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d bmy=%0d last=%0b",
                             o_x_chroma, o_luma_y, o_b_minus_y, o_last_of_group);
            end else begin
                want = pending_xyb.pop_front();
                if (o_x_chroma !== want.x || o_luma_y !== want.y
                        || o_b_minus_y !== want.bmy || o_last_of_group !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%0d y=%0d bmy=%0d last=%0b, got x=%0d y=%0d bmy=%0d last=%0b",
                                 want.x, want.y, want.bmy, want.last,
                                 o_x_chroma, o_luma_y, o_b_minus_y, o_last_of_group);
                end
            end
        end
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < 24);
        end
    end

    task automatic test_curve_extremes();
        logic [15:0] vals[10];
        vals = '{16'd0, 16'd1, 16'd2649, 16'd2650, 16'd2651, 16'd3000,
                 16'h5555, 16'hAAAA, 16'hFFFE, 16'hFFFF};
        for (int lin = 0; lin < 2; lin++) begin
            configure(lin[0], 9'd256, 9'd256);
            foreach (vals[k])
                send_pixel(vals[k], vals[(k + 3) % 10], vals[(k + 7) % 10]);
            send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
        end
    endtask

    task automatic test_group_sizes();
        // small groups, zero sizes acting as one, oversized ones clipped
        configure(1'b0, 9'd3, 9'd2);
        repeat (14) send_pixel(pick_sample(), pick_sample(), pick_sample());
        configure(1'b1, 9'd0, 9'd0);
        repeat (4) send_pixel(pick_sample(), pick_sample(), pick_sample());
        configure(1'b0, 9'd511, 9'd300);
        repeat (6) send_pixel(pick_sample(), pick_sample(), pick_sample());
        // shrink the group mid-way so the counters sit past the new bounds
        configure(1'b0, 9'd6, 9'd5);
        repeat (20) send_pixel(pick_sample(), pick_sample(), pick_sample());
        configure(1'b0, 9'd2, 9'd1);
        repeat (6) send_pixel(pick_sample(), pick_sample(), pick_sample());
    endtask

    task automatic test_backpressure();
        configure(1'b0, 9'd4, 9'd4);
        calm     = 1'b1;
        hold_req = 200;
        repeat (60) send_pixel(pick_sample(), pick_sample(), pick_sample());
        calm = 1'b0;
    endtask

    task automatic test_random();
        logic [8:0] w, h;
        for (int ph = 0; ph < 25; ph++) begin
            w = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 9));
            h = ($urandom_range(9) == 0) ? 9'($urandom) : 9'($urandom_range(1, 9));
            if (ph == 3) w = 9'd256;
            if (ph == 4) h = 9'd1;
            configure(1'($urandom), w, h);
            calm = (ph == 10);
            repeat (45) send_pixel(pick_sample(), pick_sample(), pick_sample());
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_stall        <= 1'b0;
        i_red_sample   <= '0;
        i_green_sample <= '0;
        i_blue_sample  <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        mismatches = 0;
        calm       = 1'b0;
        hold_req   = 0;
        hold_left  = 0;
        mdl_linear = 1'b0;
        mdl_width  = 9'd256;
        mdl_height = 9'd256;
        mdl_col    = 0;
        mdl_row    = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_curve_extremes();
        test_group_sizes();
        test_backpressure();
        test_random();

        drain();
        if (mismatches == 0 && pending_xyb.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
